FILE: src/bilinear_point_splat_grid_macros.svh
// Assertion macros shared by the gridding block.
`ifndef BILINEAR_POINT_SPLAT_GRID_MACROS_SVH
`define BILINEAR_POINT_SPLAT_GRID_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is low.
`define BPSG_ASSERT_IMP(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("same-cycle implication failed");
// Next-cycle implication, disabled while reset is low.
`define BPSG_ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("next-cycle implication failed");
`else
`define BPSG_ASSERT_IMP(name, clk, rstn, pre, post)
`define BPSG_ASSERT_NEXT(name, clk, rstn, pre, post)
`endif
`endif

FILE: src/bpsg_pkg.sv
package bpsg_pkg;

    // Default sizes of the grid and the fixed-point format.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;

    // Dividend and divisor widths of the mean-height divider.
    localparam int DIV_DW = 64;
    localparam int DIV_VW = 32;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_SPLAT = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_SCALE_X     = 3'd2,
        REG_SCALE_Y     = 3'd3,
        REG_GRID_WIDTH  = 3'd4,
        REG_GRID_HEIGHT = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_CHECK,
        ST_BASE,
        ST_READ,
        ST_MULZ,
        ST_WRITE,
        ST_CELL_RD,
        ST_CELL_WAIT,
        ST_DIV,
        ST_DONE
    } state_t;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: src/bpsg_ram.sv
module bpsg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/bpsg_div.sv
module bpsg_div #(
    parameter int DW = bpsg_pkg::DIV_DW,
    parameter int VW = bpsg_pkg::DIV_VW
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DW-1:0]         dividend,
    input  logic [VW-1:0]         divisor,
    output logic [DW-1:0]         quotient,
    output bpsg_pkg::div_status_t status
);

    localparam int CNTW = $clog2(DW + 1);

    logic [CNTW-1:0] cnt_reg;
    logic            done_reg;
    logic [DW-1:0]   quot_reg;
    logic [VW-1:0]   rem_reg;
    logic [VW-1:0]   div_reg;
    logic [VW:0]     trial;
    logic            fits;

    // One quotient bit per cycle, restoring scheme.
    assign trial = {rem_reg, quot_reg[DW-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNTW'(DW);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end else if (cnt_reg != '0) begin
            quot_reg <= {quot_reg[DW-2:0], fits};
            rem_reg  <= fits ? VW'(trial - {1'b0, div_reg}) : VW'(trial);
        end
    end

    assign quotient    = quot_reg;
    assign status.busy = cnt_reg != '0;
    assign status.done = done_reg;

endmodule

FILE: src/bilinear_point_splat_grid.sv
// Bilinear point-splat gridder.
// Items enter on the s_ channel (valid/ready): a command with a point or a cell
// index. Each item gives exactly one result on the m_ channel (valid/ready).
// Clear zeroes both stores, one cell per cycle.
// Splat maps the point (difference, scale, bounds check, base address), then
// updates each neighbor in reach in turn (read, weight times height, write back).
// Each neighbor is a read-modify-write of a single cell in the shared store ports.
// Read fetches the cell and, for an in-range cell that was hit, divides with a
// one-bit-per-cycle divider.
// One item is in work at a time; the next can be taken in the cycle after the result
// of the previous one has been loaded into the output register.
// Configuration writes on cfg_we take effect at once; write only while idle.
// After reset the block runs a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells,
// with s_ready low, and gives no result for it.
// Finished results sit in an output register; the next item is accepted while
// a result waits, and a stalled receiver holds the block in its final state
// until the output register frees.
`include "bilinear_point_splat_grid_macros.svh"

module bilinear_point_splat_grid #(
    parameter int MAX_WIDTH  = bpsg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bpsg_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = bpsg_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_point_z,
    input  logic [15:0]        s_cell_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_cell_height,
    output logic               m_cell_hit,
    output logic               m_cell_sparse,
    output logic               m_point_dropped
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
    localparam int YW    = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9;
    localparam int FB    = FRAC_BITS;
    localparam int PW    = 64 - 2 * FB;
    localparam int CW    = 34 + FB;

    localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MIN = -SUM_MAX;
    localparam logic [FB:0]        ONE     = {1'b1, {FB{1'b0}}};

    // Configuration registers.
    logic signed [31:0] origin_x_reg, origin_y_reg;
    logic [31:0]        scale_x_reg, scale_y_reg;
    logic [8:0]         grid_width_reg, grid_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            scale_x_reg     <= 32'd65536;
            scale_y_reg     <= 32'd65536;
            grid_width_reg  <= 9'd256;
            grid_height_reg <= 9'd256;
        end else if (cfg_we) begin
            unique case (bpsg_pkg::reg_idx_t'(cfg_addr))
                bpsg_pkg::REG_ORIGIN_X:    origin_x_reg    <= cfg_wdata;
                bpsg_pkg::REG_ORIGIN_Y:    origin_y_reg    <= cfg_wdata;
                bpsg_pkg::REG_SCALE_X:     scale_x_reg     <= cfg_wdata;
                bpsg_pkg::REG_SCALE_Y:     scale_y_reg     <= cfg_wdata;
                bpsg_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[8:0];
                bpsg_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // Grid size in use, saturated to the store dimensions.
    logic [XW-1:0] w_eff;
    logic [YW-1:0] h_eff;
    assign w_eff = (XW'(grid_width_reg) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH)
                                                          : XW'(grid_width_reg);
    assign h_eff = (YW'(grid_height_reg) > YW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT)
                                                            : YW'(grid_height_reg);

    bpsg_pkg::state_t state_reg, state_next;

    // Item and datapath registers.
    logic signed [31:0] px_in_reg, py_in_reg, z_reg;
    logic [15:0]        idx_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic [63:0]        gx_reg, gy_reg;
    logic [FB-1:0]      fx_reg, fy_reg;
    logic [XW-1:0]      cx_reg;
    logic [YW-1:0]      cy_reg;
    logic               xin_reg, yin_reg;
    logic [AW-1:0]      base_reg, addr_reg, clr_addr_reg;
    logic [1:0]         k_reg;
    logic [FB:0]        s_reg;
    logic signed [CW-1:0] c_reg;
    logic               in_range_reg;
    logic               report_reg;
    logic signed [31:0] res_height_reg;
    logic               res_hit_reg, res_sparse_reg, res_drop_reg;
    logic               m_valid_reg;
    logic signed [31:0] m_height_reg;
    logic               m_hit_reg, m_sparse_reg, m_drop_reg;

    // Store ports.
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   wt_wdata, wt_rdata;
    logic [63:0]   hs_wdata, hs_rdata;

    bpsg_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_weight_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (wt_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (wt_rdata)
    );

    bpsg_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_height_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (hs_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (hs_rdata)
    );

    // Divider for the mean height.
    logic                  div_start;
    logic [63:0]           div_dividend;
    logic [63:0]           div_quot;
    bpsg_pkg::div_status_t div_stat;
    logic                  hs_neg_reg;

    assign div_dividend = hs_rdata[63] ? 64'(-hs_rdata) : hs_rdata;

    bpsg_div #(.DW(64), .VW(32)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (wt_rdata),
        .quotient (div_quot),
        .status   (div_stat)
    );

    // Mapping results of the registered products.
    logic [PW-1:0] cell_x, cell_y;
    logic          outside;
    assign cell_x  = gx_reg[63:2*FB];
    assign cell_y  = gy_reg[63:2*FB];
    assign outside = (64'(cell_x) >= 64'(w_eff)) || (64'(cell_y) >= 64'(h_eff));

    // Corner weight and address.
    logic [FB:0]       fac_a, fac_b;
    logic [2*FB+1:0]   wprod;
    logic              corner_ok;
    logic [AW-1:0]     corner_addr;
    assign fac_a       = k_reg[0] ? {1'b0, fx_reg} : ONE - {1'b0, fx_reg};
    assign fac_b       = k_reg[1] ? {1'b0, fy_reg} : ONE - {1'b0, fy_reg};
    assign wprod       = fac_a * fac_b;
    assign corner_ok   = (!k_reg[0] || xin_reg) && (!k_reg[1] || yin_reg);
    assign corner_addr = base_reg + (k_reg[0] ? AW'(1) : '0)
                       + (k_reg[1] ? AW'(w_eff) : '0);

    // Saturating accumulation of weight and weighted height.
    logic [32:0]        wt_sum;
    logic signed [64:0] hs_sum;
    assign wt_sum = {1'b0, wt_rdata} + 33'(s_reg);
    assign hs_sum = 65'($signed(hs_rdata)) + 65'(c_reg);
    always_comb begin
        wt_wdata = wt_sum[32] ? 32'hFFFF_FFFF : wt_sum[31:0];
        priority if (hs_sum > SUM_MAX) begin
            hs_wdata = SUM_MAX[63:0];
        end else if (hs_sum < SUM_MIN) begin
            hs_wdata = SUM_MIN[63:0];
        end else begin
            hs_wdata = hs_sum[63:0];
        end
        if (state_reg == bpsg_pkg::ST_CLEAR) begin
            wt_wdata = '0;
            hs_wdata = '0;
        end
    end

    // Signed, saturated mean from the divider's magnitude.
    logic signed [31:0] mean_sat;
    always_comb begin
        if (hs_neg_reg) begin
            mean_sat = (div_quot > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-div_quot);
        end else begin
            mean_sat = (div_quot > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(div_quot);
        end
    end

    logic out_free, accept;
    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bpsg_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and store controls.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = addr_reg;
        ram_raddr  = corner_addr;
        div_start  = 1'b0;
        unique case (state_reg)
            bpsg_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = report_reg ? bpsg_pkg::ST_DONE : bpsg_pkg::ST_IDLE;
                end
            end
            bpsg_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (bpsg_pkg::cmd_t'(s_command))
                        bpsg_pkg::CMD_CLEAR: state_next = bpsg_pkg::ST_CLEAR;
                        bpsg_pkg::CMD_SPLAT: state_next = bpsg_pkg::ST_DIFF;
                        bpsg_pkg::CMD_READ:  state_next = bpsg_pkg::ST_CELL_RD;
                        bpsg_pkg::CMD_NONE:  state_next = bpsg_pkg::ST_DONE;
                        default:             state_next = bpsg_pkg::ST_DONE;
                    endcase
                end
            end
            bpsg_pkg::ST_DIFF: state_next = bpsg_pkg::ST_MUL;
            bpsg_pkg::ST_MUL: begin
                state_next = (dx_reg < 0 || dy_reg < 0) ? bpsg_pkg::ST_DONE
                                                        : bpsg_pkg::ST_CHECK;
            end
            bpsg_pkg::ST_CHECK: begin
                state_next = outside ? bpsg_pkg::ST_DONE : bpsg_pkg::ST_BASE;
            end
            bpsg_pkg::ST_BASE: state_next = bpsg_pkg::ST_READ;
            bpsg_pkg::ST_READ: begin
                if (corner_ok) begin
                    ram_re     = 1'b1;
                    state_next = bpsg_pkg::ST_MULZ;
                end else if (k_reg == 2'd3) begin
                    state_next = bpsg_pkg::ST_DONE;
                end
            end
            bpsg_pkg::ST_MULZ: state_next = bpsg_pkg::ST_WRITE;
            bpsg_pkg::ST_WRITE: begin
                ram_we     = 1'b1;
                state_next = (k_reg == 2'd3) ? bpsg_pkg::ST_DONE : bpsg_pkg::ST_READ;
            end
            bpsg_pkg::ST_CELL_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(idx_reg);
                state_next = bpsg_pkg::ST_CELL_WAIT;
            end
            bpsg_pkg::ST_CELL_WAIT: begin
                if (in_range_reg && wt_rdata != '0) begin
                    div_start  = 1'b1;
                    state_next = bpsg_pkg::ST_DIV;
                end else begin
                    state_next = bpsg_pkg::ST_DONE;
                end
            end
            bpsg_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    state_next = bpsg_pkg::ST_DONE;
                end
            end
            bpsg_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = bpsg_pkg::ST_IDLE;
                end
            end
            default: state_next = bpsg_pkg::ST_IDLE;
        endcase
    end

    // Control counters and result flags that reset clears.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            report_reg   <= 1'b0;
            k_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (state_reg == bpsg_pkg::ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (accept) begin
                clr_addr_reg <= '0;
                report_reg   <= 1'b1;
            end
            if (state_reg == bpsg_pkg::ST_BASE) begin
                k_reg <= '0;
            end else if ((state_reg == bpsg_pkg::ST_READ && !corner_ok)
                         || state_reg == bpsg_pkg::ST_WRITE) begin
                k_reg <= k_reg + 1'b1;
            end
            if (state_reg == bpsg_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            px_in_reg      <= s_point_x;
            py_in_reg      <= s_point_y;
            z_reg          <= s_point_z;
            idx_reg        <= s_cell_index;
            in_range_reg   <= 32'(s_cell_index) < 32'(DEPTH);
            res_height_reg <= '0;
            res_hit_reg    <= 1'b0;
            res_sparse_reg <= 1'b0;
            res_drop_reg   <= 1'b0;
        end
        unique case (state_reg)
            bpsg_pkg::ST_DIFF: begin
                dx_reg <= 33'(px_in_reg) - 33'(origin_x_reg);
                dy_reg <= 33'(py_in_reg) - 33'(origin_y_reg);
            end
            bpsg_pkg::ST_MUL: begin
                gx_reg <= dx_reg[31:0] * scale_x_reg;
                gy_reg <= dy_reg[31:0] * scale_y_reg;
                if (dx_reg < 0 || dy_reg < 0) begin
                    res_drop_reg <= 1'b1;
                end
            end
            bpsg_pkg::ST_CHECK: begin
                fx_reg  <= gx_reg[2*FB-1:FB];
                fy_reg  <= gy_reg[2*FB-1:FB];
                cx_reg  <= XW'(cell_x);
                cy_reg  <= YW'(cell_y);
                xin_reg <= (XW + 1)'(XW'(cell_x)) + 1'b1 < (XW + 1)'(w_eff);
                yin_reg <= (YW + 1)'(YW'(cell_y)) + 1'b1 < (YW + 1)'(h_eff);
                if (outside) begin
                    res_drop_reg <= 1'b1;
                end
            end
            bpsg_pkg::ST_BASE: begin
                base_reg <= AW'(cx_reg) + AW'(cy_reg) * AW'(w_eff);
            end
            bpsg_pkg::ST_READ: begin
                s_reg    <= wprod[2*FB:FB];
                addr_reg <= corner_addr;
            end
            bpsg_pkg::ST_MULZ: begin
                c_reg <= CW'(z_reg) * CW'($signed({1'b0, s_reg}));
            end
            bpsg_pkg::ST_CELL_WAIT: begin
                hs_neg_reg <= hs_rdata[63];
                if (in_range_reg) begin
                    res_hit_reg    <= wt_rdata != '0;
                    res_sparse_reg <= wt_rdata < 32'(ONE);
                end else begin
                    res_sparse_reg <= 1'b1;
                end
            end
            bpsg_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    res_height_reg <= mean_sat;
                end
            end
            default: ;
        endcase
        if (state_reg == bpsg_pkg::ST_DONE && out_free) begin
            m_height_reg <= res_height_reg;
            m_hit_reg    <= res_hit_reg;
            m_sparse_reg <= res_sparse_reg;
            m_drop_reg   <= res_drop_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cell_height   = m_height_reg;
    assign m_cell_hit      = m_hit_reg;
    assign m_cell_sparse   = m_sparse_reg;
    assign m_point_dropped = m_drop_reg;

    `BPSG_ASSERT_IMP(a_store_write_in_update, aclk, aresetn, ram_we, state_reg == bpsg_pkg::ST_WRITE || state_reg == bpsg_pkg::ST_CLEAR)
    `BPSG_ASSERT_NEXT(a_div_runs_after_start, aclk, aresetn, div_start, div_stat.busy)
    `BPSG_ASSERT_IMP(a_result_fields_exclusive, aclk, aresetn, m_valid_reg, !(m_drop_reg && (m_hit_reg || m_sparse_reg)))

endmodule
